// File: rtl/tnn_pkg.sv
package tnn_pkg;

    localparam int MAX_POINTS      = 16;
    localparam int NEIGHBOUR_COUNT = 3;
    localparam int SLOTS           = 3;

    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int COORD_W = 16;
    localparam int PT_W    = 2 * COORD_W;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W + 1;
    localparam int DIST_W  = 34;
    localparam int DOUT_W  = 33;
    localparam int OIDX_W  = 4;

    localparam logic [DIST_W-1:0] MAX_DIST_RST = 34'd10000000000;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] dsq;
    } t_slot;

    typedef struct packed {
        logic store;
        logic start;
        logic ref_rd;
        logic ref_ld;
        logic issue;
        logic out_ld;
        logic next_pt;
        logic count_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic pipe_busy;
        logic last_point;
        logic out_free;
    } t_dp_sts;

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_REF   = 6'b000010,
        S_REFW  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_DRAIN = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    function automatic logic [OIDX_W-1:0] out_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W+OIDX_W-1:0] ext;
        ext = {{OIDX_W{1'b0}}, idx};
        return ext[OIDX_W-1:0];
    endfunction

endpackage

// File: rtl/tnn_ram.sv
module tnn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tnn_ctrl.sv
module tnn_ctrl
    import tnn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_is_last,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   in_xfer;

    assign o_in_stall = (r_state != S_LOAD);
    assign in_xfer    = i_in_valid && (r_state == S_LOAD);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (in_xfer) begin
                    o_cmd.store = 1'b1;
                    if (i_is_last) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_REF;
                    end
                end
            end
            S_REF: begin
                o_cmd.ref_rd = 1'b1;
                n_state      = S_REFW;
            end
            S_REFW: begin
                o_cmd.ref_ld = 1'b1;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    if (i_sts.last_point) begin
                        o_cmd.count_clr = 1'b1;
                        n_state         = S_LOAD;
                    end else begin
                        o_cmd.next_pt = 1'b1;
                        n_state       = S_REF;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/tnn_dp.sv
module tnn_dp
    import tnn_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic                i_cfg_wr_en,
    input  logic [DIST_W-1:0]   i_cfg_wr_data,
    input  logic [COORD_W-1:0]  i_coord_x,
    input  logic [COORD_W-1:0]  i_coord_y,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [OIDX_W-1:0]   o_point_index,
    output logic [OIDX_W-1:0]   o_first_index,
    output logic [DOUT_W-1:0]   o_first_dist_sq,
    output logic                o_first_valid,
    output logic [OIDX_W-1:0]   o_second_index,
    output logic [DOUT_W-1:0]   o_second_dist_sq,
    output logic                o_second_valid,
    output logic [OIDX_W-1:0]   o_third_index,
    output logic [DOUT_W-1:0]   o_third_dist_sq,
    output logic                o_third_valid,
    output logic                o_last_result
);

    logic [DIST_W-1:0]  r_max_dist;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_i;
    logic [IDX_W-1:0]   r_j;
    logic [COORD_W-1:0] r_ref_x;
    logic [COORD_W-1:0] r_ref_y;

    logic               full;
    logic [IDX_W-1:0]   raddr;
    logic [PT_W-1:0]    rdata;
    logic [COORD_W-1:0] pt_x;
    logic [COORD_W-1:0] pt_y;

    // distance pipeline: read, difference, square, sum, insert
    logic               r_p0_v;
    logic [IDX_W-1:0]   r_p0_j;
    logic               r_p1_v;
    logic [IDX_W-1:0]   r_p1_j;
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic               r_p2_v;
    logic [IDX_W-1:0]   r_p2_j;
    logic [SQ_W-1:0]    r_sqx;
    logic [SQ_W-1:0]    r_sqy;
    logic               r_p3_v;
    logic [IDX_W-1:0]   r_p3_j;
    logic [DIST_W-1:0]  r_d;

    logic [DIFF_W-1:0]        dx_n;
    logic [DIFF_W-1:0]        dy_n;
    logic signed [2*DIFF_W-1:0] prod_x;
    logic signed [2*DIFF_W-1:0] prod_y;

    t_slot r_slot [SLOTS];
    t_slot n_slot [SLOTS];
    t_slot cand;
    logic  lt [SLOTS];

    logic                r_out_valid;
    logic [OIDX_W-1:0]   r_out_pidx;
    logic                r_out_last;
    t_slot               r_out_slot [SLOTS];

    assign full  = (r_count == CNT_W'(MAX_POINTS));
    assign raddr = i_cmd.ref_rd ? r_i : r_j;
    assign pt_x  = rdata[PT_W-1:COORD_W];
    assign pt_y  = rdata[COORD_W-1:0];

    tnn_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store && !full),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({i_coord_x, i_coord_y}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_sts.scan_last  = (CNT_W'(r_j) == r_count - 1'b1);
    assign o_sts.pipe_busy  = r_p0_v || r_p1_v || r_p2_v || r_p3_v;
    assign o_sts.last_point = ((CNT_W'(r_i) + 1'b1) == r_count);
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist <= MAX_DIST_RST;
            r_count    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_dist <= i_cfg_wr_data;
            end
            if (i_cmd.count_clr) begin
                r_count <= '0;
            end else if (i_cmd.store && !full) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_i <= '0;
        end else if (i_cmd.next_pt) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.ref_ld) begin
            r_j     <= '0;
            r_ref_x <= pt_x;
            r_ref_y <= pt_y;
        end else if (i_cmd.issue) begin
            r_j <= r_j + 1'b1;
        end
    end

    assign dx_n   = {r_ref_x[COORD_W-1], r_ref_x} - {pt_x[COORD_W-1], pt_x};
    assign dy_n   = {r_ref_y[COORD_W-1], r_ref_y} - {pt_y[COORD_W-1], pt_y};
    assign prod_x = r_dx * r_dx;
    assign prod_y = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_v <= 1'b0;
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
        end else begin
            r_p0_v <= i_cmd.issue;
            r_p1_v <= r_p0_v && (r_p0_j != r_i);
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0_j <= r_j;
        r_p1_j <= r_p0_j;
        r_dx   <= dx_n;
        r_dy   <= dy_n;
        r_p2_j <= r_p1_j;
        r_sqx  <= prod_x[SQ_W-1:0];
        r_sqy  <= prod_y[SQ_W-1:0];
        r_p3_j <= r_p2_j;
        r_d    <= DIST_W'(r_sqx) + DIST_W'(r_sqy);
    end

    // sorted insert; equal distance keeps the earlier (lower) index ahead
    always_comb begin
        cand.valid = r_p3_v && (r_d < r_max_dist);
        cand.idx   = r_p3_j;
        cand.dsq   = r_d;
        for (int s = 0; s < SLOTS; s++) begin
            lt[s]     = !r_slot[s].valid || (r_d < r_slot[s].dsq);
            n_slot[s] = r_slot[s];
        end
        if (cand.valid) begin
            if (lt[0]) begin
                n_slot[2] = r_slot[1];
                n_slot[1] = r_slot[0];
                n_slot[0] = cand;
            end else if (lt[1]) begin
                n_slot[2] = r_slot[1];
                n_slot[1] = cand;
            end else if (lt[2]) begin
                n_slot[2] = cand;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < SLOTS; s++) begin
            if (!i_rst_n || i_cmd.ref_ld) begin
                r_slot[s] <= '0;
            end else begin
                r_slot[s] <= n_slot[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_pidx <= out_idx(r_i);
            r_out_last <= o_sts.last_point;
            for (int s = 0; s < SLOTS; s++) begin
                if (r_slot[s].valid && (s < NEIGHBOUR_COUNT)) begin
                    r_out_slot[s] <= r_slot[s];
                end else begin
                    r_out_slot[s] <= '0;
                end
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_point_index    = r_out_pidx;
    assign o_last_result    = r_out_last;
    assign o_first_index    = out_idx(r_out_slot[0].idx);
    assign o_first_dist_sq  = r_out_slot[0].dsq[DOUT_W-1:0];
    assign o_first_valid    = r_out_slot[0].valid;
    assign o_second_index   = out_idx(r_out_slot[1].idx);
    assign o_second_dist_sq = r_out_slot[1].dsq[DOUT_W-1:0];
    assign o_second_valid   = r_out_slot[1].valid;
    assign o_third_index    = out_idx(r_out_slot[2].idx);
    assign o_third_dist_sq  = r_out_slot[2].dsq[DOUT_W-1:0];
    assign o_third_valid    = r_out_slot[2].valid;

endmodule

// File: rtl/three_nearest_neighbours.sv
// Brute-force three-nearest-neighbour search over up to MAX_POINTS signed
// 2-D points. Points load one per cycle; points past capacity are dropped,
// and the point with is_last starts the search. The block then stalls its
// input and gives one result per loaded point, in index order, listing the
// three nearest other points by squared distance (ties to the lower index),
// counting only distances strictly below max_dist_sq. The point store has
// one read port feeding a single difference/square/sum/insert pipeline,
// one stored point per cycle. The result sits in an output register, so
// the next search runs while it waits, and new points are taken while the
// last result waits. The user must see that max_dist_sq is written only
// while the block is idle; the block does not enforce this.
module three_nearest_neighbours
    import tnn_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [DIST_W-1:0]   i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [COORD_W-1:0]  i_coord_x,
    input  logic [COORD_W-1:0]  i_coord_y,
    input  logic                i_is_last,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [OIDX_W-1:0]   o_point_index,
    output logic [OIDX_W-1:0]   o_first_index,
    output logic [DOUT_W-1:0]   o_first_dist_sq,
    output logic                o_first_valid,
    output logic [OIDX_W-1:0]   o_second_index,
    output logic [DOUT_W-1:0]   o_second_dist_sq,
    output logic                o_second_valid,
    output logic [OIDX_W-1:0]   o_third_index,
    output logic [DOUT_W-1:0]   o_third_dist_sq,
    output logic                o_third_valid,
    output logic                o_last_result
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    tnn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_is_last  (i_is_last),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    tnn_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_point_index    (o_point_index),
        .o_first_index    (o_first_index),
        .o_first_dist_sq  (o_first_dist_sq),
        .o_first_valid    (o_first_valid),
        .o_second_index   (o_second_index),
        .o_second_dist_sq (o_second_dist_sq),
        .o_second_valid   (o_second_valid),
        .o_third_index    (o_third_index),
        .o_third_dist_sq  (o_third_dist_sq),
        .o_third_valid    (o_third_valid),
        .o_last_result    (o_last_result)
    );

endmodule

// File: rtl/tnn_checker.sv
module tnn_checker
    import tnn_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                i_is_last,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [OIDX_W-1:0]   o_point_index,
    input logic [OIDX_W-1:0]   o_first_index,
    input logic [DOUT_W-1:0]   o_first_dist_sq,
    input logic                o_first_valid,
    input logic [OIDX_W-1:0]   o_second_index,
    input logic [DOUT_W-1:0]   o_second_dist_sq,
    input logic                o_second_valid,
    input logic [DOUT_W-1:0]   o_third_dist_sq,
    input logic                o_third_valid,
    input logic                o_last_result
);

    // stalled result transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_point_index)
            && $stable(o_first_dist_sq) && $stable(o_last_result)))
        else $error("result changed while stalled");

    // a final point starts the search, so input stalls next
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_is_last) |=> o_in_stall)
        else $error("input taken after final point");

    // empty first slot carries zeros and all later slots are empty
    a_empty_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_first_valid) |-> (o_first_index == '0
            && o_first_dist_sq == '0 && !o_second_valid && !o_third_valid))
        else $error("bad empty slot");

    // neighbours in ascending distance
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_third_valid) |-> (o_second_valid
            && o_second_dist_sq >= o_first_dist_sq
            && o_third_dist_sq >= o_second_dist_sq
            && o_second_index != o_first_index))
        else $error("neighbours out of order");

endmodule

bind three_nearest_neighbours tnn_checker u_tnn_checker (.*);

// File: tb/sv/tb_three_nearest_neighbours.sv
`timescale 1ns / 1ps

module tb_three_nearest_neighbours;
    import tnn_pkg::*;

    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 40;
    localparam int DRAIN_LIMIT      = 200000;
    localparam int PHASES           = 8;
    localparam int PHASE_ITEMS      = 28;

    localparam logic [DIST_W-1:0] DIST_LIMIT_MAX = '1;

    localparam int SPREAD_WIDE    = 0;
    localparam int SPREAD_CLUSTER = 1;
    localparam int SPREAD_GRID    = 2;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } t_point_item;

    typedef struct packed {
        logic [OIDX_W-1:0] point_index;
        logic [OIDX_W-1:0] first_index;
        logic [DOUT_W-1:0] first_dist_sq;
        logic              first_valid;
        logic [OIDX_W-1:0] second_index;
        logic [DOUT_W-1:0] second_dist_sq;
        logic              second_valid;
        logic [OIDX_W-1:0] third_index;
        logic [DOUT_W-1:0] third_dist_sq;
        logic              third_valid;
        logic              last_result;
    } t_nb_result;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic [DIST_W-1:0]  i_cfg_wr_data = '0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    logic [COORD_W-1:0] i_coord_x     = '0;
    logic [COORD_W-1:0] i_coord_y     = '0;
    logic               i_is_last     = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    logic [OIDX_W-1:0]  o_point_index;
    logic [OIDX_W-1:0]  o_first_index;
    logic [DOUT_W-1:0]  o_first_dist_sq;
    logic               o_first_valid;
    logic [OIDX_W-1:0]  o_second_index;
    logic [DOUT_W-1:0]  o_second_dist_sq;
    logic               o_second_valid;
    logic [OIDX_W-1:0]  o_third_index;
    logic [DOUT_W-1:0]  o_third_dist_sq;
    logic               o_third_valid;
    logic               o_last_result;

    t_point_item        point_queue[$];
    t_nb_result         neighbour_expect[$];
    t_point_item        offered;
    bit                 offer_live   = 1'b0;

    logic [COORD_W-1:0] stored_x [MAX_POINTS];
    logic [COORD_W-1:0] stored_y [MAX_POINTS];
    int                 stored_count = 0;
    logic [DIST_W-1:0]  dist_limit   = MAX_DIST_RST;

    int                 in_wait      = 0;
    int                 out_wait     = 0;
    bit                 quiet_mode   = 1'b0;
    bit                 hold_request = 1'b0;
    logic               long_hold    = 1'b0;
    int                 error_count  = 0;

    three_nearest_neighbours u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .i_is_last        (i_is_last),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_point_index    (o_point_index),
        .o_first_index    (o_first_index),
        .o_first_dist_sq  (o_first_dist_sq),
        .o_first_valid    (o_first_valid),
        .o_second_index   (o_second_index),
        .o_second_dist_sq (o_second_dist_sq),
        .o_second_valid   (o_second_valid),
        .o_third_index    (o_third_index),
        .o_third_dist_sq  (o_third_dist_sq),
        .o_third_valid    (o_third_valid),
        .o_last_result    (o_last_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_error(input string what, input longint unsigned got,
                                input longint unsigned want);
        $display("ERROR t=%0t %s: got %0d, want %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic compare_field(input string what, input longint unsigned got,
                                 input longint unsigned want);
        if (got !== want) begin
            report_error(what, got, want);
        end
    endtask

    function automatic logic [DIST_W-1:0] sq_dist(input int a, input int b);
        longint dx;
        longint dy;
        dx = longint'($signed(stored_x[a])) - longint'($signed(stored_x[b]));
        dy = longint'($signed(stored_y[a])) - longint'($signed(stored_y[b]));
        return DIST_W'(dx * dx + dy * dy);
    endfunction

    // stores the point if there is room; on the last point, searches every stored point
    task automatic accept_point(input t_point_item p);
        t_nb_result        r;
        int                s_idx  [SLOTS];
        logic [DIST_W-1:0] s_dist [SLOTS];
        bit                s_ok   [SLOTS];
        logic [DIST_W-1:0] bound;
        logic [DIST_W-1:0] d;
        bit                taken;
        bit                searching;
        if (stored_count < MAX_POINTS) begin
            stored_x[stored_count] = p.x;
            stored_y[stored_count] = p.y;
            stored_count++;
        end
        if (p.last) begin
            for (int i = 0; i < stored_count; i++) begin
                for (int s = 0; s < SLOTS; s++) begin
                    s_idx[s]  = 0;
                    s_dist[s] = '0;
                    s_ok[s]   = 1'b0;
                end
                searching = 1'b1;
                for (int s = 0; s < SLOTS && s < NEIGHBOUR_COUNT && searching; s++) begin
                    bound = dist_limit;
                    for (int j = 0; j < stored_count; j++) begin
                        taken = (j == i);
                        for (int k = 0; k < s; k++) begin
                            if (s_ok[k] && s_idx[k] == j) begin
                                taken = 1'b1;
                            end
                        end
                        d = sq_dist(i, j);
                        if (!taken && d < bound) begin
                            bound     = d;
                            s_idx[s]  = j;
                            s_dist[s] = d;
                            s_ok[s]   = 1'b1;
                        end
                    end
                    searching = s_ok[s];
                end
                r.point_index    = OIDX_W'(i);
                r.first_index    = OIDX_W'(s_idx[0]);
                r.first_dist_sq  = s_dist[0][DOUT_W-1:0];
                r.first_valid    = s_ok[0];
                r.second_index   = OIDX_W'(s_idx[1]);
                r.second_dist_sq = s_dist[1][DOUT_W-1:0];
                r.second_valid   = s_ok[1];
                r.third_index    = OIDX_W'(s_idx[2]);
                r.third_dist_sq  = s_dist[2][DOUT_W-1:0];
                r.third_valid    = s_ok[2];
                r.last_result    = (i + 1 == stored_count);
                neighbour_expect.push_back(r);
            end
            stored_count = 0;
        end
    endtask

    always @(posedge i_clk) begin : drive_points
        bit holding;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            holding = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                accept_point(offered);
                holding = 1'b0;
            end
            if (!holding) begin
                if (in_wait > 0) begin
                    in_wait--;
                end else if (point_queue.size() != 0) begin
                    offered = point_queue.pop_front();
                    i_coord_x <= offered.x;
                    i_coord_y <= offered.y;
                    i_is_last <= offered.last;
                    holding = 1'b1;
                    in_wait = quiet_mode ? 0 : $urandom_range(0, 7);
                end
            end
            offer_live = holding;
            i_in_valid <= holding;
        end
    end

    always @(posedge i_clk) begin : check_neighbours
        t_nb_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (neighbour_expect.size() == 0) begin
                    report_error("unexpected result, point_index", o_point_index, 0);
                end else begin
                    want = neighbour_expect.pop_front();
                    compare_field("point_index", o_point_index, want.point_index);
                    compare_field("first_index", o_first_index, want.first_index);
                    compare_field("first_dist_sq", o_first_dist_sq, want.first_dist_sq);
                    compare_field("first_valid", o_first_valid, want.first_valid);
                    compare_field("second_index", o_second_index, want.second_index);
                    compare_field("second_dist_sq", o_second_dist_sq, want.second_dist_sq);
                    compare_field("second_valid", o_second_valid, want.second_valid);
                    compare_field("third_index", o_third_index, want.third_index);
                    compare_field("third_dist_sq", o_third_dist_sq, want.third_dist_sq);
                    compare_field("third_valid", o_third_valid, want.third_valid);
                    compare_field("last_result", o_last_result, want.last_result);
                end
                out_wait = quiet_mode ? 0 : $urandom_range(0, 7);
            end else if (out_wait > 0) begin
                out_wait--;
            end
            i_out_stall <= long_hold || (out_wait > 0);
        end
    end

    // one long receiver hold-off so the block backs up into its input
    initial begin : receiver_hold
        wait (hold_request);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    task automatic add_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic last);
        t_point_item p;
        p.x    = x;
        p.y    = y;
        p.last = last;
        point_queue.push_back(p);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(input int spread,
                                                      input logic [COORD_W-1:0] base);
        case (spread)
            SPREAD_CLUSTER: return base + COORD_W'($urandom_range(0, 63)) - COORD_W'(32);
            SPREAD_GRID:    return COORD_W'($urandom_range(0, 3));
            default:        return COORD_W'($urandom());
        endcase
    endfunction

    task automatic add_point_set(input int n, input int spread);
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        bx = COORD_W'($urandom());
        by = COORD_W'($urandom());
        for (int k = 0; k < n; k++) begin
            add_point(pick_coord(spread, bx), pick_coord(spread, by), k == n - 1);
        end
    endtask

    task automatic write_dist_limit(input logic [DIST_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        dist_limit    = value;
    endtask

    // sender pauses here until every expected result is back
    task automatic wait_for_idle();
        int waited;
        waited = 0;
        while ((point_queue.size() != 0 || offer_live || neighbour_expect.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (neighbour_expect.size() != 0) begin
            report_error("results never arrived", 0, neighbour_expect.size());
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [DIST_W-1:0] limit;
        int                added;
        int                n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single point: all slots empty
        add_point(16'h0123, 16'hFEDC, 1'b1);
        // coordinate extremes
        add_point(16'h8000, 16'h8000, 1'b0);
        add_point(16'h7FFF, 16'h7FFF, 1'b0);
        add_point(16'h7FFF, 16'h8000, 1'b0);
        add_point(16'h8000, 16'h7FFF, 1'b0);
        add_point(16'h0000, 16'h0000, 1'b1);
        // equal distances, ties to the lower index
        add_point(16'h0000, 16'h0000, 1'b0);
        add_point(16'h0001, 16'h0000, 1'b0);
        add_point(16'hFFFF, 16'h0000, 1'b0);
        add_point(16'h0000, 16'h0001, 1'b0);
        add_point(16'h0000, 16'hFFFF, 1'b1);
        // coincident points
        add_point(16'h0005, 16'h0005, 1'b0);
        add_point(16'h0005, 16'h0005, 1'b0);
        add_point(16'h0005, 16'h0005, 1'b1);
        wait_for_idle();

        // distance equal to the limit is rejected
        write_dist_limit(DIST_W'(25));
        add_point(16'h0000, 16'h0000, 1'b0);
        add_point(16'h0003, 16'h0004, 1'b0);
        add_point(16'h0000, 16'h0005, 1'b0);
        add_point(16'h0001, 16'h0001, 1'b1);
        wait_for_idle();

        write_dist_limit('0);
        add_point(16'h000A, 16'h000A, 1'b0);
        add_point(16'h000A, 16'h000A, 1'b0);
        add_point(16'h000B, 16'h000A, 1'b1);
        wait_for_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0:       limit = DIST_LIMIT_MAX;
                1:       limit = {2'($urandom_range(0, 3)), 32'($urandom())};
                2:       limit = DIST_W'($urandom_range(0, 20000));
                default: limit = MAX_DIST_RST;
            endcase
            write_dist_limit(limit);
            quiet_mode = ph[0];
            if (ph == 5) begin
                hold_request = 1'b1;
            end
            added = 0;
            // overfull set: trailing points and the last one are dropped
            if (ph == 0) begin
                add_point_set(20, SPREAD_CLUSTER);
                added = 20;
            end
            while (added < PHASE_ITEMS) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20)
                                                : $urandom_range(1, 8);
                add_point_set(n, $urandom_range(SPREAD_WIDE, SPREAD_GRID));
                added += n;
            end
            // stray points that join the next set
            if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++) begin
                    add_point(pick_coord(SPREAD_WIDE, '0), pick_coord(SPREAD_WIDE, '0), 1'b0);
                end
            end
            wait_for_idle();
        end

        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #(20_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
